// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// If the antecedent holds at an edge, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// If the antecedent holds at an edge, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fbfla_pkg.sv =====
// Package with the item types, codes and defaults of the block free-list allocator.
package fbfla_pkg;

   localparam int NumBlocksDefault = 256;

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_REINIT = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   localparam logic [8:0] BlockCountReset = 9'd256;
   localparam logic [8:0] FreeCountMax    = 9'h1FF;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] block_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] granted_index;
      logic [8:0] free_count;
   } rsp_item_type;

endpackage

// ===== design/fixed_block_free_list_allocator_core.sv =====
// Block free-list allocator: hands out block indexes from a LIFO free list kept as a linked
// list in a next-link RAM, and gives never-used blocks from a fresh counter once the list is
// empty. Every request item (allocate, free, reinitialize) yields one result item with a
// status and the free count. An item goes through an accept step, in which a free writes
// its link and an allocate reads the successor of the list head, and a finish step, in
// which the RAM read data becomes the new head and the result moves to the output register
// once that register is empty or being read. No new item is accepted until the finish step
// is done, but the output register lets the next item be accepted while a result still waits.
// block_count is used live and is loaded into the free count at reset and on reinitialize.
module fixed_block_free_list_allocator_core
   import fbfla_pkg::*;
#(
   parameter int NUM_BLOCKS = NumBlocksDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data
);

   localparam int IdxW  = $clog2(NUM_BLOCKS);
   localparam int HeadW = $clog2(NUM_BLOCKS + 1);
   localparam int CmpW  = (HeadW > 9) ? HeadW : 9;
   localparam logic [HeadW-1:0] HeadEmpty = HeadW'(NUM_BLOCKS);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_FINISH = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [8:0]       block_count_ff;
   logic [HeadW-1:0] head_ff, head_in;
   logic [HeadW-1:0] fresh_ff, fresh_in;
   logic [8:0]       total_ff, total_in;
   logic             pop_ff, pop_in;
   rsp_item_type     res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             ram_wr_en;
   logic [IdxW-1:0]  ram_wr_addr;
   logic             ram_rd_en;
   logic [HeadW-1:0] ram_rd_data;

   logic [CmpW-1:0]  eff_count;
   logic [CmpW-1:0]  count_ext;
   logic             list_nonempty;
   logic             fresh_avail;
   logic             idx_ok;
   logic [8:0]       total_dec;
   logic [8:0]       total_inc;
   logic             accept;
   logic             slot_free;

   // Effective pool size: the register limited to the RAM depth.
   assign count_ext     = CmpW'(block_count_ff);
   assign eff_count     = (count_ext > CmpW'(NUM_BLOCKS)) ? CmpW'(NUM_BLOCKS) : count_ext;
   assign list_nonempty = (head_ff != HeadEmpty);
   assign fresh_avail   = (CmpW'(fresh_ff) < eff_count);
   assign idx_ok        = (CmpW'(req_item.block_index) < eff_count);
   assign total_dec     = (total_ff == 9'd0) ? total_ff : total_ff - 9'd1;
   assign total_inc     = (total_ff == FreeCountMax) ? total_ff : total_ff + 9'd1;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign ram_wr_addr = IdxW'(req_item.block_index);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fresh_in     = fresh_ff;
      total_in     = total_ff;
      pop_in       = pop_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pop_in               = 1'b0;
               res_in.status        = STAT_OK;
               res_in.granted_index = 8'd0;
               case (req_item.command)
                  CMD_ALLOC: begin
                     if (list_nonempty) begin
                        res_in.granted_index = 8'(head_ff);
                        ram_rd_en            = 1'b1;
                        pop_in               = 1'b1;
                        total_in             = total_dec;
                     end else if (fresh_avail) begin
                        res_in.granted_index = 8'(fresh_ff);
                        fresh_in             = fresh_ff + HeadW'(1);
                        total_in             = total_dec;
                     end else begin
                        res_in.status = STAT_EMPTY;
                     end
                  end
                  CMD_FREE: begin
                     if (idx_ok) begin
                        ram_wr_en = 1'b1;
                        head_in   = HeadW'(req_item.block_index);
                        total_in  = total_inc;
                     end else begin
                        res_in.status = STAT_RANGE;
                     end
                  end
                  CMD_REINIT: begin
                     head_in  = HeadEmpty;
                     fresh_in = '0;
                     total_in = 9'(eff_count);
                  end
                  default: begin
                  end
               endcase
               res_in.free_count = total_in;
               state_in          = S_FINISH;
            end
         end
         S_FINISH: begin
            // The popped head's successor arrives from the RAM in this cycle.
            if (pop_ff) begin
               head_in = ram_rd_data;
               pop_in  = 1'b0;
            end
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         block_count_ff <= BlockCountReset;
         head_ff        <= HeadEmpty;
         fresh_ff       <= '0;
         total_ff       <= 9'(BlockCountReset > 9'(NUM_BLOCKS) && NUM_BLOCKS < 512 ?
                              9'(NUM_BLOCKS) : BlockCountReset);
         pop_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         total_ff     <= total_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            block_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   fbfla_ram #(
      .Width (HeadW),
      .Depth (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (head_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff[IdxW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== design/fbfla_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module fbfla_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fbfla_checker.sv =====
// Port-level checker for the block free-list allocator, bound to the top level.
`include "assert_macros.svh"

module fbfla_checker
   import fbfla_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   // A stalled result item must hold.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "result item changed while stalled")

   // An error result never carries a granted index.
   `ASSERT_IMPLIES(a_err_no_grant, clock, reset, rsp_valid && rsp_item.status != STAT_OK, rsp_item.granted_index == 8'd0, "granted index set on an error")

   // One item is worked on at a time, so no item is taken right after another.
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "item accepted in back-to-back cycles")

   // No result is shown directly after reset.
   `ASSERT_IMPLIES(a_reset_clear, clock, reset, $fell(reset), !rsp_valid, "result valid right after reset")

endmodule

bind fixed_block_free_list_allocator_core fbfla_checker u_fbfla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
